[sv/avlt_pkg.sv]
package avlt_pkg;

	localparam int unsigned MaxBodyBytes = 1048576;
	localparam int unsigned BodyCap = (MaxBodyBytes < 1048576) ? MaxBodyBytes : 1048576;
	localparam int unsigned OffW = $clog2(BodyCap + 1);
	localparam int unsigned OutW = 20;

	localparam int unsigned QueueDepth = 4;
	localparam int unsigned QPtrW = $clog2(QueueDepth);
	localparam int unsigned QCntW = $clog2(QueueDepth + 1);

	localparam logic [1:0] KindByte = 2'd0;
	localparam logic [1:0] KindPatch = 2'd1;
	localparam logic [1:0] KindDone = 2'd2;

	localparam logic [7:0] TagKey = 8'h17;
	localparam logic [7:0] TagInter = 8'h27;
	localparam logic [7:0] TagAvcPacket = 8'h01;
	localparam logic [2:0] HdrLastIdx = 3'd4;
	localparam int unsigned HdrBytes = 5;
	localparam int unsigned SlotBytes = 4;

	localparam logic [4:0] NalSps = 5'd7;
	localparam logic [4:0] NalPps = 5'd8;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       key_frame;
		logic       frame_last;
	} au_req_t;

	typedef struct packed {
		logic [1:0]      kind;
		logic [OutW-1:0] body_offset;
		logic [7:0]      body_byte;
		logic [OutW-1:0] nal_length;
		logic            body_empty;
		logic            run_last;
	} tag_req_t;

	typedef struct packed {
		logic       start;
		logic [1:0] nzero;
		logic       has_byte;
		logic [7:0] data;
		logic       last;
		logic       key;
	} cmd_t;

endpackage

[sv/avlt_front.sv]
module avlt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              au_valid,
	output logic              au_stall,
	input  avlt_pkg::au_req_t au,
	output logic              cmd_valid,
	output avlt_pkg::cmd_t    cmd,
	input  logic              cmd_pop
);

	localparam logic [1:0] HeldMax = 2'd3;

	logic [1:0] held_q;
	logic [1:0] held_n;
	avlt_pkg::cmd_t c;
	logic accept;
	logic push;

	avlt_pkg::cmd_t mem_q [avlt_pkg::QueueDepth];
	logic [avlt_pkg::QPtrW-1:0] wptr_q;
	logic [avlt_pkg::QPtrW-1:0] rptr_q;
	logic [avlt_pkg::QCntW-1:0] cnt_q;

	always_comb begin
		c = '0;
		held_n = held_q;
		c.key = au.key_frame;
		c.last = au.frame_last;
		c.data = au.data_byte;
		if (au.data_byte == 8'h00) begin
			if (held_q != HeldMax) begin
				held_n = held_q + 2'd1;
			end else begin
				c.has_byte = 1'b1;
			end
		end else if (au.data_byte == 8'h01 && held_q[1]) begin
			c.start = 1'b1;
			held_n = 2'd0;
		end else begin
			c.nzero = held_q;
			c.has_byte = 1'b1;
			held_n = 2'd0;
		end
		if (au.frame_last) begin
			c.nzero = c.nzero | held_n;
			held_n = 2'd0;
		end
	end

	assign au_stall = (cnt_q == avlt_pkg::QCntW'(avlt_pkg::QueueDepth));
	assign accept = au_valid && !au_stall;
	assign push = accept && (c.start || c.has_byte || c.nzero != 2'd0 || c.last);

	assign cmd_valid = (cnt_q != '0);
	assign cmd = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= 2'd0;
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				held_q <= held_n;
			end
			if (push) begin
				wptr_q <= wptr_q + avlt_pkg::QPtrW'(1);
			end
			if (cmd_pop) begin
				rptr_q <= rptr_q + avlt_pkg::QPtrW'(1);
			end
			if (push && !cmd_pop) begin
				cnt_q <= cnt_q + avlt_pkg::QCntW'(1);
			end else if (!push && cmd_pop) begin
				cnt_q <= cnt_q - avlt_pkg::QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= c;
		end
	end

endmodule

[sv/avlt_back.sv]
module avlt_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  avlt_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               tag_valid,
	input  logic               tag_stall,
	output avlt_pkg::tag_req_t tag
);

	typedef enum logic [4:0] {
		PH_IDLE  = 5'b00001,
		PH_START = 5'b00010,
		PH_PAY   = 5'b00100,
		PH_CLOSE = 5'b01000,
		PH_DONE  = 5'b10000
	} phase_t;

	function automatic phase_t first_phase(avlt_pkg::cmd_t c);
		phase_t p;
		if (c.start) begin
			p = PH_START;
		end else if (c.nzero != 2'd0 || c.has_byte) begin
			p = PH_PAY;
		end else if (c.last) begin
			p = PH_CLOSE;
		end else begin
			p = PH_IDLE;
		end
		return p;
	endfunction

	function automatic logic [7:0] hdr_byte(logic [2:0] idx, logic key);
		logic [7:0] v;
		if (idx == 3'd0) begin
			v = key ? avlt_pkg::TagKey : avlt_pkg::TagInter;
		end else if (idx == 3'd1) begin
			v = avlt_pkg::TagAvcPacket;
		end else begin
			v = 8'h00;
		end
		return v;
	endfunction

	localparam logic [avlt_pkg::OffW-1:0] Cap = avlt_pkg::OffW'(avlt_pkg::BodyCap);

	phase_t ph_q, ph_n;
	avlt_pkg::cmd_t cur_q, cur_n;
	logic [2:0] hcnt_q, hcnt_n;
	logic inside_q, inside_n;
	logic first_q, first_n;
	logic kept_q, kept_n;
	logic hdr_done_q, hdr_done_n;
	logic [avlt_pkg::OffW-1:0] wo_q, wo_n;
	logic [avlt_pkg::OffW-1:0] slot_q, slot_n;
	logic [avlt_pkg::OffW-1:0] pc_q, pc_n;

	logic [7:0] pay_val;
	logic type_keep;
	logic [avlt_pkg::OffW-1:0] wo_p4;
	logic fit1, fit4, fit5;
	logic res_v;
	avlt_pkg::tag_req_t res;
	logic op_done;
	logic cmd_end;
	logic load;
	logic advance;

	logic pend_v_q;
	logic pend_fin_q;
	avlt_pkg::tag_req_t pend_q;
	logic pend_push;
	avlt_pkg::tag_req_t push_req;

	avlt_pkg::tag_req_t oq_q [avlt_pkg::QueueDepth];
	logic [avlt_pkg::QPtrW-1:0] oq_wptr_q;
	logic [avlt_pkg::QPtrW-1:0] oq_rptr_q;
	logic [avlt_pkg::QCntW-1:0] oq_cnt_q;
	logic oq_push;
	logic tag_pop;

	assign pay_val = (cur_q.nzero != 2'd0) ? 8'h00 : cur_q.data;
	assign type_keep = (pay_val[4:0] != avlt_pkg::NalSps) && (pay_val[4:0] != avlt_pkg::NalPps);
	assign wo_p4 = wo_q + avlt_pkg::OffW'(avlt_pkg::SlotBytes);
	assign fit1 = wo_q < Cap;
	assign fit4 = wo_p4 <= Cap;
	assign fit5 = wo_p4 < Cap;

	always_comb begin
		res_v = 1'b0;
		res = '0;
		op_done = 1'b0;
		cur_n = cur_q;
		hcnt_n = hcnt_q;
		inside_n = inside_q;
		first_n = first_q;
		kept_n = kept_q;
		hdr_done_n = hdr_done_q;
		wo_n = wo_q;
		slot_n = slot_q;
		pc_n = pc_q;
		case (ph_q)
			PH_START: begin
				res_v = inside_q && !first_q && kept_q;
				res.kind = avlt_pkg::KindPatch;
				res.body_offset = avlt_pkg::OutW'(slot_q);
				res.nal_length = avlt_pkg::OutW'(pc_q);
				inside_n = 1'b1;
				first_n = 1'b1;
				kept_n = 1'b0;
				cur_n.start = 1'b0;
				op_done = 1'b1;
			end
			PH_PAY: begin
				res.kind = avlt_pkg::KindByte;
				if (inside_q && first_q && type_keep && !hdr_done_q) begin
					res_v = 1'b1;
					res.body_offset = avlt_pkg::OutW'(hcnt_q);
					res.body_byte = hdr_byte(hcnt_q, cur_q.key);
					if (hcnt_q == avlt_pkg::HdrLastIdx) begin
						hcnt_n = 3'd0;
						hdr_done_n = 1'b1;
						wo_n = avlt_pkg::OffW'(avlt_pkg::HdrBytes);
					end else begin
						hcnt_n = hcnt_q + 3'd1;
					end
				end else begin
					op_done = 1'b1;
					if (cur_q.nzero != 2'd0) begin
						cur_n.nzero = cur_q.nzero - 2'd1;
					end else begin
						cur_n.has_byte = 1'b0;
					end
					res.body_byte = pay_val;
					if (inside_q) begin
						if (first_q) begin
							first_n = 1'b0;
							if (type_keep && fit4) begin
								kept_n = 1'b1;
								slot_n = wo_q;
								if (fit5) begin
									res_v = 1'b1;
									res.body_offset = avlt_pkg::OutW'(wo_p4);
									wo_n = wo_q + avlt_pkg::OffW'(avlt_pkg::SlotBytes + 1);
									pc_n = avlt_pkg::OffW'(1);
								end else begin
									wo_n = wo_p4;
									pc_n = '0;
								end
							end else begin
								kept_n = 1'b0;
							end
						end else if (kept_q && fit1) begin
							res_v = 1'b1;
							res.body_offset = avlt_pkg::OutW'(wo_q);
							wo_n = wo_q + avlt_pkg::OffW'(1);
							pc_n = pc_q + avlt_pkg::OffW'(1);
						end
					end
				end
			end
			PH_CLOSE: begin
				res_v = inside_q && !first_q && kept_q;
				res.kind = avlt_pkg::KindPatch;
				res.body_offset = avlt_pkg::OutW'(slot_q);
				res.nal_length = avlt_pkg::OutW'(pc_q);
				inside_n = 1'b0;
				first_n = 1'b0;
				kept_n = 1'b0;
				op_done = 1'b1;
			end
			PH_DONE: begin
				res_v = 1'b1;
				res.kind = avlt_pkg::KindDone;
				res.body_offset = avlt_pkg::OutW'(wo_q);
				res.body_empty = !hdr_done_q;
				hcnt_n = 3'd0;
				inside_n = 1'b0;
				first_n = 1'b0;
				kept_n = 1'b0;
				hdr_done_n = 1'b0;
				wo_n = '0;
				slot_n = '0;
				pc_n = '0;
				op_done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ph_n = ph_q;
		cmd_end = 1'b0;
		if (op_done) begin
			if (ph_q == PH_CLOSE) begin
				ph_n = PH_DONE;
			end else if (ph_q == PH_DONE) begin
				ph_n = PH_IDLE;
			end else begin
				ph_n = first_phase(cur_n);
			end
			cmd_end = (ph_n == PH_IDLE);
		end
		load = (ph_q == PH_IDLE || cmd_end) && cmd_valid;
		if (load) begin
			ph_n = first_phase(cmd);
		end
	end

	assign tag_valid = (oq_cnt_q != '0);
	assign tag = oq_q[oq_rptr_q];
	assign tag_pop = tag_valid && !tag_stall;
	assign advance = (oq_cnt_q != avlt_pkg::QCntW'(avlt_pkg::QueueDepth)) || tag_pop;
	assign cmd_pop = load && advance;

	// A result is held in the pending register so that run_last is known when it leaves.
	assign pend_push = pend_v_q && (res_v || cmd_end || pend_fin_q);
	always_comb begin
		push_req = pend_q;
		push_req.run_last = pend_fin_q || (cmd_end && !res_v);
	end
	assign oq_push = pend_push && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= PH_IDLE;
			hcnt_q <= 3'd0;
			inside_q <= 1'b0;
			first_q <= 1'b0;
			kept_q <= 1'b0;
			hdr_done_q <= 1'b0;
			wo_q <= '0;
			slot_q <= '0;
			pc_q <= '0;
			pend_v_q <= 1'b0;
			pend_fin_q <= 1'b0;
			oq_wptr_q <= '0;
			oq_rptr_q <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (advance) begin
				ph_q <= ph_n;
				hcnt_q <= hcnt_n;
				inside_q <= inside_n;
				first_q <= first_n;
				kept_q <= kept_n;
				hdr_done_q <= hdr_done_n;
				wo_q <= wo_n;
				slot_q <= slot_n;
				pc_q <= pc_n;
				if (res_v) begin
					pend_v_q <= 1'b1;
					pend_fin_q <= cmd_end;
				end else if (pend_push) begin
					pend_v_q <= 1'b0;
					pend_fin_q <= 1'b0;
				end
			end
			if (oq_push) begin
				oq_wptr_q <= oq_wptr_q + avlt_pkg::QPtrW'(1);
			end
			if (tag_pop) begin
				oq_rptr_q <= oq_rptr_q + avlt_pkg::QPtrW'(1);
			end
			if (oq_push && !tag_pop) begin
				oq_cnt_q <= oq_cnt_q + avlt_pkg::QCntW'(1);
			end else if (!oq_push && tag_pop) begin
				oq_cnt_q <= oq_cnt_q - avlt_pkg::QCntW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (load) begin
				cur_q <= cmd;
			end else begin
				cur_q <= cur_n;
			end
			if (res_v) begin
				pend_q <= res;
			end
		end
		if (oq_push) begin
			oq_q[oq_wptr_q] <= push_req;
		end
	end

endmodule

[sv/annexb_to_length_prefixed_video_tag_unit.sv]
// Channel  Direction  Handshake            Request type
// au       in         au_valid, au_stall   avlt_pkg::au_req_t, one Annex B byte
// tag      out        tag_valid, tag_stall avlt_pkg::tag_req_t, one body result
//
// The front accepts one byte per cycle while its four-entry command queue has room.
// The back handles a start code and each payload byte that a request releases; it emits
// the five tag header bytes when it opens the tag, and a done result at frame end.
// Reset clears all control state at once; a zero byte only held back pushes no command.
// A stalled tag channel fills the four-entry output queue, then halts the back,
// then fills the command queue, and only then raises au_stall.
module annexb_to_length_prefixed_video_tag_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               au_valid,
	output logic               au_stall,
	input  avlt_pkg::au_req_t  au,
	output logic               tag_valid,
	input  logic               tag_stall,
	output avlt_pkg::tag_req_t tag
);

	logic cmd_valid;
	logic cmd_pop;
	avlt_pkg::cmd_t cmd;

	avlt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.au_valid  (au_valid),
		.au_stall  (au_stall),
		.au        (au),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop)
	);

	avlt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.tag_valid (tag_valid),
		.tag_stall (tag_stall),
		.tag       (tag)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cmd_valid)
		else $error("command queue popped while empty");

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag.kind == avlt_pkg::KindDone |-> tag.run_last)
		else $error("frame done request is not the last of its run");

	a_kind_legal: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid |-> (tag.kind == avlt_pkg::KindByte || tag.kind == avlt_pkg::KindPatch
			|| tag.kind == avlt_pkg::KindDone))
		else $error("illegal result kind");

	a_len_only_patch: assert property (@(posedge clk) disable iff (!arst_n)
		tag_valid && tag.kind != avlt_pkg::KindPatch |-> tag.nal_length == '0)
		else $error("length present on a request that is not a patch");

endmodule

[verif/annexb_to_length_prefixed_video_tag_unit_tb.sv]
module annexb_to_length_prefixed_video_tag_unit_tb;

	localparam int MaxResults = 12;
	localparam int RandomItems = 370;
	localparam int TailItems = 60;
	localparam int HoldCycles = 300;
	localparam int HoldAfter = 80;
	localparam int DrainCycles = 40;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic au_valid = 1'b0;
	logic au_stall;
	avlt_pkg::au_req_t au = '0;
	logic tag_valid;
	logic tag_stall = 1'b1;
	avlt_pkg::tag_req_t tag;

	annexb_to_length_prefixed_video_tag_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.au_valid(au_valid),
		.au_stall(au_stall),
		.au(au),
		.tag_valid(tag_valid),
		.tag_stall(tag_stall),
		.tag(tag)
	);

	always #4 clk = ~clk;

	avlt_pkg::au_req_t au_backlog[$];
	logic [7:0] frame_bytes[$];
	avlt_pkg::tag_req_t want_tags[$];
	avlt_pkg::tag_req_t step_tags[$];
	avlt_pkg::tag_req_t want;

	int errors = 0;
	int taken_count = 0;
	bit au_taken = 1'b0;
	bit tag_hold = 1'b0;
	int send_gap = 0;
	int stall_gap = 0;

	// Converter state kept by the predictor.
	int unsigned zero_run;
	bit in_nal;
	bit hdr_pending;
	bit nal_keep;
	bit tag_started;
	int unsigned next_off;
	int unsigned slot_off;
	int unsigned nal_bytes;
	bit step_key;

	task automatic report_mismatch(input string what, input int unsigned got,
		input int unsigned exp_val);
		$display("tag check failed: %0s got 0x%0h expected 0x%0h at %0t",
			what, got, exp_val, $realtime);
		errors++;
	endtask

	task automatic check_field(input string what, input int unsigned got,
		input int unsigned exp_val);
		if (got != exp_val) begin
			report_mismatch(what, got, exp_val);
		end
	endtask

	task automatic clear_state();
		zero_run = 0;
		in_nal = 1'b0;
		hdr_pending = 1'b0;
		nal_keep = 1'b0;
		tag_started = 1'b0;
		next_off = 0;
		slot_off = 0;
		nal_bytes = 0;
	endtask

	task automatic push_result(input logic [1:0] k, input int unsigned off,
		input logic [7:0] b, input int unsigned len, input logic empty);
		avlt_pkg::tag_req_t r;
		if (step_tags.size() < MaxResults) begin
			r.kind = k;
			r.body_offset = off[avlt_pkg::OutW-1:0];
			r.body_byte = b;
			r.nal_length = len[avlt_pkg::OutW-1:0];
			r.body_empty = empty;
			r.run_last = 1'b0;
			step_tags.insert(step_tags.size(), r);
		end
	endtask

	task automatic take_payload(input logic [7:0] b);
		logic [4:0] unit_code;
		if (!in_nal) begin
			return;
		end
		if (hdr_pending) begin
			unit_code = b[4:0];
			hdr_pending = 1'b0;
			nal_keep = (unit_code != avlt_pkg::NalSps) && (unit_code != avlt_pkg::NalPps);
			if (nal_keep) begin
				if (!tag_started) begin
					push_result(avlt_pkg::KindByte, 0,
						step_key ? avlt_pkg::TagKey : avlt_pkg::TagInter, 0, 1'b0);
					push_result(avlt_pkg::KindByte, 1, avlt_pkg::TagAvcPacket, 0, 1'b0);
					for (int unsigned i = 2; i < avlt_pkg::HdrBytes; i++) begin
						push_result(avlt_pkg::KindByte, i, 8'h00, 0, 1'b0);
					end
					tag_started = 1'b1;
					next_off = avlt_pkg::HdrBytes;
				end
				if (next_off + avlt_pkg::SlotBytes > avlt_pkg::BodyCap) begin
					nal_keep = 1'b0;
				end else begin
					slot_off = next_off;
					next_off += avlt_pkg::SlotBytes;
					nal_bytes = 0;
				end
			end
		end
		if (nal_keep && next_off < avlt_pkg::BodyCap) begin
			push_result(avlt_pkg::KindByte, next_off, b, 0, 1'b0);
			next_off++;
			nal_bytes++;
		end
	endtask

	task automatic close_nal();
		if (in_nal && !hdr_pending && nal_keep) begin
			push_result(avlt_pkg::KindPatch, slot_off, 8'h00, nal_bytes, 1'b0);
		end
		in_nal = 1'b0;
		hdr_pending = 1'b0;
		nal_keep = 1'b0;
	endtask

	task automatic flush_held();
		while (zero_run > 0) begin
			take_payload(8'h00);
			zero_run--;
		end
	endtask

	task automatic convert_byte(input avlt_pkg::au_req_t req);
		step_tags.delete();
		step_key = req.key_frame;
		if (req.data_byte == 8'h00) begin
			if (zero_run < 3) begin
				zero_run++;
			end else begin
				take_payload(8'h00);
			end
		end else if (req.data_byte == 8'h01 && zero_run >= 2) begin
			close_nal();
			in_nal = 1'b1;
			hdr_pending = 1'b1;
			nal_keep = 1'b0;
			zero_run = 0;
		end else begin
			flush_held();
			take_payload(req.data_byte);
		end
		if (req.frame_last) begin
			flush_held();
			close_nal();
			push_result(avlt_pkg::KindDone, next_off, 8'h00, 0, !tag_started);
			clear_state();
		end
		if (step_tags.size() > 0) begin
			step_tags[step_tags.size() - 1].run_last = 1'b1;
		end
		foreach (step_tags[i]) begin
			want_tags.insert(want_tags.size(), step_tags[i]);
		end
	endtask

	task automatic add_item(input logic [7:0] b, input logic key, input logic last);
		avlt_pkg::au_req_t r;
		r.data_byte = b;
		r.key_frame = key;
		r.frame_last = last;
		au_backlog.insert(au_backlog.size(), r);
	endtask

	task automatic queue_pattern(input logic [8*32-1:0] bytes, input int n, input logic key);
		for (int i = n - 1; i >= 0; i--) begin
			add_item(bytes[i*8 +: 8], key, i == 0);
		end
	endtask

	function automatic logic [7:0] rand_byte();
		int unsigned pick;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			return 8'h00;
		end else if (pick == 3) begin
			return 8'h01;
		end
		return 8'($urandom_range(0, 255));
	endfunction

	task automatic commit_frame(input logic key);
		if (frame_bytes.size() == 0) begin
			frame_bytes.insert(frame_bytes.size(), 8'h00);
		end
		foreach (frame_bytes[i]) begin
			add_item(frame_bytes[i], key, i == frame_bytes.size() - 1);
		end
		frame_bytes.delete();
	endtask

	task automatic make_frame();
		logic key;
		int nals;
		int len;
		key = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 7) == 0) begin
			len = $urandom_range(1, 12);
			repeat (len) frame_bytes.insert(frame_bytes.size(), rand_byte());
		end else begin
			if ($urandom_range(0, 3) == 0) begin
				len = $urandom_range(1, 3);
				repeat (len) frame_bytes.insert(frame_bytes.size(),
					8'($urandom_range(0, 255)));
			end
			nals = $urandom_range(1, 4);
			repeat (nals) begin
				if ($urandom_range(0, 1) == 0) begin
					frame_bytes.insert(frame_bytes.size(), 8'h00);
				end
				frame_bytes.insert(frame_bytes.size(), 8'h00);
				frame_bytes.insert(frame_bytes.size(), 8'h00);
				frame_bytes.insert(frame_bytes.size(), 8'h01);
				case ($urandom_range(0, 7))
					0: begin
						frame_bytes.insert(frame_bytes.size(),
							{3'($urandom_range(0, 7)), avlt_pkg::NalSps});
					end
					1: begin
						frame_bytes.insert(frame_bytes.size(),
							{3'($urandom_range(0, 7)), avlt_pkg::NalPps});
					end
					2: begin
					end
					default: begin
						frame_bytes.insert(frame_bytes.size(), 8'($urandom_range(0, 255)));
					end
				endcase
				len = $urandom_range(0, 10);
				repeat (len) frame_bytes.insert(frame_bytes.size(), rand_byte());
			end
		end
		commit_frame(key);
	endtask

	// Stimulus, reset and end of run.
	initial begin
		clear_state();
		queue_pattern(144'hAB_00_00_00_01_65_00_00_00_00_FF_00_00_01_00_00_01_E8, 18, 1'b1);
		queue_pattern(56'h00_00_01_67_00_00_01, 7, 1'b1);
		queue_pattern(48'hAB_00_00_01_41_00, 6, 1'b0);
		while (au_backlog.size() < RandomItems) begin
			make_frame();
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		while (au_backlog.size() != 0 || au_valid) begin
			@(posedge clk);
		end
		while (want_tags.size() != 0) begin
			@(posedge clk);
		end
		repeat (DrainCycles) @(posedge clk);
		if (want_tags.size() != 0) begin
			report_mismatch("expected results left over", 0, want_tags.size());
		end
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// The receiver holds off long enough to back the block up into its input.
	initial begin
		while (!(arst_n && taken_count >= HoldAfter)) begin
			@(posedge clk);
		end
		tag_hold = 1'b1;
		repeat (HoldCycles) @(posedge clk);
		tag_hold = 1'b0;
	end

	always @(negedge clk) begin
		if (arst_n && (!au_valid || au_taken)) begin
			if (send_gap > 0) begin
				send_gap--;
				au_valid <= 1'b0;
			end else if (au_backlog.size() >= TailItems && $urandom_range(0, 7) == 0) begin
				send_gap = $urandom_range(0, 4);
				au_valid <= 1'b0;
			end else if (au_backlog.size() > 0) begin
				au <= au_backlog.pop_front();
				au_valid <= 1'b1;
			end else begin
				au_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (stall_gap > 0) begin
			stall_gap--;
		end else if (au_backlog.size() >= TailItems && $urandom_range(0, 5) == 0) begin
			stall_gap = $urandom_range(1, 5);
		end
		tag_stall <= tag_hold || (stall_gap > 0);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			au_taken = au_valid && !au_stall;
			if (au_taken) begin
				convert_byte(au);
				taken_count++;
			end
			if (tag_valid && !tag_stall) begin
				if (want_tags.size() == 0) begin
					report_mismatch("result with none expected, kind", 32'(tag.kind), 0);
				end else begin
					want = want_tags.pop_front();
					check_field("kind", 32'(tag.kind), 32'(want.kind));
					check_field("body_offset", 32'(tag.body_offset), 32'(want.body_offset));
					check_field("body_byte", 32'(tag.body_byte), 32'(want.body_byte));
					check_field("nal_length", 32'(tag.nal_length), 32'(want.nal_length));
					check_field("body_empty", 32'(tag.body_empty), 32'(want.body_empty));
					check_field("run_last", 32'(tag.run_last), 32'(want.run_last));
				end
			end
		end
	end

endmodule

[sim.f]
sv/avlt_pkg.sv
sv/avlt_front.sv
sv/avlt_back.sv
sv/annexb_to_length_prefixed_video_tag_unit.sv
verif/annexb_to_length_prefixed_video_tag_unit_tb.sv
